// ----- rtl/frustum_sphere_cull_assert.svh -----
`ifndef FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_ASSERT_SVH
// same-cycle implication, sampled on clk, off during rst
`define FSC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define FSC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ----- rtl/fsc_pkg.sv -----
package fsc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ACT_LD_PROJ = 2'd0;
  localparam logic [1:0] ACT_LD_MV   = 2'd1;
  localparam logic [1:0] ACT_TEST    = 2'd2;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

// ----- rtl/fsc_ram.sv -----
module fsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fsc_mul.sv -----
module fsc_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- rtl/fsc_iter.sv -----
// Shared restoring unit: floor square root (2 bits a step) or
// quotient (1 bit a step) on one compare/subtract.
module fsc_iter #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fsc_pkg::iter_ctl_t  ctl,
  input  logic [63:0]         opnd,
  input  logic [31:0]         divisor,
  output fsc_pkg::iter_stat_t stat,
  output logic [63:0]         result
);

  localparam int DIV_STEPS  = 32 + FRAC_BITS;
  localparam int SQRT_STEPS = 32;
  localparam int CW         = $clog2(DIV_STEPS);

  logic          busy;
  logic          done;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [63:0]   src;
  logic [35:0]   rem;
  logic [63:0]   res;

  logic [35:0] rem_sh;
  logic [35:0] sub;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    if (is_div) begin
      rem_sh = {rem[34:0], src[63]};
      sub    = {4'd0, divisor};
    end else begin
      rem_sh = {rem[33:0], src[63:62]};
      sub    = {2'd0, res[31:0], 2'b01};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    ge   = !diff[36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy   <= 1'b1;
        is_div <= ctl.is_div;
        cnt    <= ctl.is_div ? CW'(DIV_STEPS - 1) : CW'(SQRT_STEPS - 1);
        src    <= opnd;
        rem    <= '0;
        res    <= '0;
      end else if (busy) begin
        rem <= ge ? diff[35:0] : rem_sh;
        res <= {res[62:0], ge};
        src <= is_div ? {src[62:0], 1'b0} : {src[61:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = res;

endmodule

// ----- rtl/frustum_sphere_cull.sv -----
// Sphere-vs-frustum cull. Loads (action 0/1) write one projection or
// modelview element. A test (action 2) holds req_stall high until its
// single visible result is registered: the clip matrix takes 64 terms,
// each read, multiplied and accumulated on the shared 32x32 multiplier;
// the work on each of the six planes is then dominated by the bit-serial
// sqrt/divide unit (one square root and four divides per plane). A test
// ends early when a plane rejects, and a plane with a zero normal skips
// its divides.
module frustum_sphere_cull #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         action,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] centre_x,
  input  logic signed [31:0] centre_y,
  input  logic signed [31:0] centre_z,
  input  logic [30:0]        sphere_radius,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               visible
);

  localparam int NW = 33 + FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_CLIP_RD, S_CLIP_MUL, S_CLIP_ACC,
    S_PL_RDW, S_PL_RDE, S_PL_SUM,
    S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_DOT_MUL, S_DOT_ACC,
    S_DIST, S_NEXT, S_FIN
  } state_t;

  state_t state;
  logic [1:0] r, c, k, i;
  logic [2:0] p;
  logic signed [65:0] acc;
  logic signed [63:0] w_reg;
  logic signed [31:0] pl [4];
  logic signed [NW-1:0] nrm [4];
  logic signed [31:0] cen [3];
  logic [30:0] rad;
  logic [31:0] len_reg;
  logic vis;

  logic req_take;
  assign req_take  = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // stores
  logic        st_we_pj, st_we_mv;
  logic [3:0]  pj_raddr, mv_raddr;
  logic [31:0] pj_rdata, mv_rdata;
  logic        clip_we;
  logic [3:0]  clip_waddr, clip_raddr;
  logic [63:0] clip_wdata, clip_rdata;

  assign st_we_pj = req_take && (action == fsc_pkg::ACT_LD_PROJ);
  assign st_we_mv = req_take && (action == fsc_pkg::ACT_LD_MV);
  assign mv_raddr = {r, k};
  assign pj_raddr = {k, c};

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_proj (
    .clk(clk), .we(st_we_pj), .waddr(element_index), .wdata(element_value),
    .raddr(pj_raddr), .rdata(pj_rdata)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_mv (
    .clk(clk), .we(st_we_mv), .waddr(element_index), .wdata(element_value),
    .raddr(mv_raddr), .rdata(mv_rdata)
  );

  fsc_ram #(.WIDTH(64), .DEPTH(16)) u_clip (
    .clk(clk), .we(clip_we), .waddr(clip_waddr), .wdata(clip_wdata),
    .raddr(clip_raddr), .rdata(clip_rdata)
  );

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  fsc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // shared sqrt / divide
  fsc_pkg::iter_ctl_t  it_ctl;
  fsc_pkg::iter_stat_t it_stat;
  logic [63:0] it_opnd, it_res;

  fsc_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
    .clk(clk), .rst(rst), .ctl(it_ctl), .opnd(it_opnd), .divisor(len_reg),
    .stat(it_stat), .result(it_res)
  );

  logic [1:0] j;
  logic signed [31:0] pl_sel;
  logic [32:0] pl_mag;
  logic signed [65:0] addend, acc_next, dist_val, neg_rad;
  logic acc_first;
  logic signed [64:0] psum;
  logic signed [31:0] psat;
  logic signed [NW-1:0] q_s;

  assign j      = p[2:1];
  assign pl_sel = pl[i];
  assign pl_mag = pl_sel[31] ? -{pl_sel[31], pl_sel} : {1'b0, pl_sel};

  always_comb begin
    unique case (state)
      S_CLIP_MUL: begin
        mul_a = $signed(mv_rdata);
        mul_b = $signed(pj_rdata);
      end
      S_SQ_MUL: begin
        mul_a = pl_sel;
        mul_b = pl_sel;
      end
      S_DOT_MUL: begin
        mul_a = 32'(nrm[i]);
        mul_b = cen[i];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    if (state == S_CLIP_ACC) begin
      addend    = 66'(prod >>> FRAC_BITS);
      acc_first = (k == 2'd0);
    end else begin
      addend    = 66'(prod);
      acc_first = (i == 2'd0);
    end
    acc_next = (acc_first ? 66'sd0 : acc) + addend;

    clip_we    = (state == S_CLIP_ACC) && (k == 2'd3);
    clip_waddr = {r, c};
    clip_wdata = acc_next[63:0];
    clip_raddr = (state == S_PL_RDE) ? {i, j} : {i, 2'd3};

    // plane coefficient, saturated to 32 bits
    psum = p[0] ? (65'(w_reg) - 65'($signed(clip_rdata)))
                : (65'(w_reg) + 65'($signed(clip_rdata)));
    if (psum[64:31] == '0 || psum[64:31] == '1) begin
      psat = psum[31:0];
    end else begin
      psat = psum[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    it_ctl.start  = (state == S_SQRT_GO) || (state == S_DIV_GO);
    it_ctl.is_div = (state == S_DIV_GO);
    it_opnd       = (state == S_DIV_GO) ? {pl_mag[31:0], 32'd0} : acc[63:0];

    q_s      = $signed({1'b0, it_res[NW-2:0]});
    dist_val = (acc >>> FRAC_BITS) + 66'(nrm[3]);
    neg_rad  = -$signed({35'd0, rad});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take && action == fsc_pkg::ACT_TEST) begin
            cen[0] <= centre_x;
            cen[1] <= centre_y;
            cen[2] <= centre_z;
            rad    <= sphere_radius;
            r      <= 2'd0;
            c      <= 2'd0;
            k      <= 2'd0;
            state  <= S_CLIP_RD;
          end
        end
        S_CLIP_RD:  state <= S_CLIP_MUL;
        S_CLIP_MUL: state <= S_CLIP_ACC;
        S_CLIP_ACC: begin
          acc   <= acc_next;
          state <= S_CLIP_RD;
          k     <= k + 2'd1;
          if (k == 2'd3) begin
            c <= c + 2'd1;
            if (c == 2'd3) begin
              r <= r + 2'd1;
              if (r == 2'd3) begin
                p     <= 3'd0;
                i     <= 2'd0;
                state <= S_PL_RDW;
              end
            end
          end
        end
        S_PL_RDW: state <= S_PL_RDE;
        S_PL_RDE: begin
          w_reg <= $signed(clip_rdata);
          state <= S_PL_SUM;
        end
        S_PL_SUM: begin
          pl[i] <= psat;
          i     <= i + 2'd1;
          state <= (i == 2'd3) ? S_SQ_MUL : S_PL_RDW;
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc <= acc_next;
          if (i == 2'd2) begin
            i     <= 2'd0;
            state <= S_SQRT_GO;
          end else begin
            i     <= i + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (it_stat.done) begin
            len_reg <= it_res[31:0];
            // zero-length normal: plane never rejects
            state   <= (it_res[31:0] == 32'd0) ? S_NEXT : S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (it_stat.done) begin
            nrm[i] <= pl_sel[31] ? -q_s : q_s;
            i      <= i + 2'd1;
            state  <= (i == 2'd3) ? S_DOT_MUL : S_DIV_GO;
          end
        end
        S_DOT_MUL: state <= S_DOT_ACC;
        S_DOT_ACC: begin
          acc <= acc_next;
          if (i == 2'd2) begin
            state <= S_DIST;
          end else begin
            i     <= i + 2'd1;
            state <= S_DOT_MUL;
          end
        end
        S_DIST: begin
          if (dist_val < neg_rad) begin
            vis   <= 1'b0;
            state <= S_FIN;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (p == 3'd5) begin
            vis   <= 1'b1;
            state <= S_FIN;
          end else begin
            p     <= p + 3'd1;
            i     <= 2'd0;
            state <= S_PL_RDW;
          end
        end
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            visible   <= vis;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fsc_checker.sv -----
`include "frustum_sphere_cull_assert.svh"

module fsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [1:0]  action,
  input logic        res_valid,
  input logic        res_stall,
  input logic        visible
);

  `FSC_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(visible), "result dropped while stalled")
  `FSC_ASSERT_IMP(a_reset_clear, $past(rst), !res_valid, "result valid right after reset")
  `FSC_ASSERT_NXT(a_test_busy, req_valid && !req_stall && action == fsc_pkg::ACT_TEST, req_stall, "test request did not hold the input")
  `FSC_ASSERT_IMP(a_res_from_test, $rose(res_valid), $past(req_stall), "result without a test in flight")

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .action(action), .res_valid(res_valid), .res_stall(res_stall), .visible(visible)
);
